>>> rtl/cpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants of the cursor position tracker.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int COORD_BITS     = 12;
	localparam int BUTTON_BITS    = 5;
	localparam int WINDOW_ID_BITS = 16;
	localparam int SPEED_BITS     = 4;
	localparam int COUNT_BITS     = 32;
	localparam int CMD_BITS       = 3;
	localparam int STATUS_BITS    = 2;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = COORD_BITS;

	// doubled delta times speed, and cursor plus that
	localparam int DELTA_BITS = COORD_BITS + SPEED_BITS + 1;
	localparam int SUM_BITS   = DELTA_BITS + 1;

	localparam int ACCEL_THRESHOLD = 6;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COORD_BITS-1:0] RESET_WIDTH    = COORD_BITS'(640);
	localparam logic [COORD_BITS-1:0] RESET_HEIGHT   = COORD_BITS'(480);
	localparam logic [COORD_BITS-1:0] RESET_CURSOR_X = COORD_BITS'(320);
	localparam logic [COORD_BITS-1:0] RESET_CURSOR_Y = COORD_BITS'(240);
	localparam logic [SPEED_BITS-1:0] RESET_SPEED    = SPEED_BITS'(1);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_MOVE    = 3'd0,
		CMD_SET     = 3'd1,
		CMD_BUTTONS = 3'd2,
		CMD_RECLAMP = 3'd3,
		CMD_GRAB    = 3'd4,
		CMD_RELEASE = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_NOT_OWNER = 2'd2
	} grab_status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_SPEED         = 3'd2,
		REG_CLIP_ENABLE   = 3'd3,
		REG_CLIP_LEFT     = 3'd4,
		REG_CLIP_TOP      = 3'd5,
		REG_CLIP_RIGHT    = 3'd6,
		REG_CLIP_BOTTOM   = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] screen_width;
		logic [COORD_BITS-1:0] screen_height;
		logic [SPEED_BITS-1:0] speed;
		logic                  clip_enable;
		logic [COORD_BITS-1:0] clip_left;
		logic [COORD_BITS-1:0] clip_top;
		logic [COORD_BITS-1:0] clip_right;
		logic [COORD_BITS-1:0] clip_bottom;
	} cfg_t;

	// classified item as it sits in the queue
	typedef struct packed {
		cmd_t                         cmd;
		logic signed [DELTA_BITS-1:0] dx;
		logic signed [DELTA_BITS-1:0] dy;
		logic [COORD_BITS-1:0]        abs_x;
		logic [COORD_BITS-1:0]        abs_y;
		logic [BUTTON_BITS-1:0]       buttons;
		logic [WINDOW_ID_BITS-1:0]    window_id;
	} entry_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]     pos_x;
		logic [COORD_BITS-1:0]     pos_y;
		logic [BUTTON_BITS-1:0]    buttons_held;
		logic [BUTTON_BITS-1:0]    new_presses;
		logic [COUNT_BITS-1:0]     move_count;
		logic [COUNT_BITS-1:0]     click_count;
		logic [COUNT_BITS-1:0]     grab_count;
		logic                      grab_held;
		logic [WINDOW_ID_BITS-1:0] grab_owner;
		grab_status_t              status;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/cpt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_if
// Valid/ready channels carrying cursor commands and cursor results.
// ----------------------------------------------------------------------------
interface cpt_in_if import cpt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_BITS-1:0]       command;
	logic [COORD_BITS-1:0]     delta_x;
	logic [COORD_BITS-1:0]     delta_y;
	logic [COORD_BITS-1:0]     abs_x;
	logic [COORD_BITS-1:0]     abs_y;
	logic [BUTTON_BITS-1:0]    button_mask;
	logic [WINDOW_ID_BITS-1:0] window_id;

	modport source (output valid, command, delta_x, delta_y, abs_x, abs_y,
		button_mask, window_id, input ready);
	modport sink (input valid, command, delta_x, delta_y, abs_x, abs_y,
		button_mask, window_id, output ready);
endinterface

interface cpt_out_if import cpt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [COORD_BITS-1:0]     pos_x;
	logic [COORD_BITS-1:0]     pos_y;
	logic [BUTTON_BITS-1:0]    buttons_held;
	logic [BUTTON_BITS-1:0]    new_presses;
	logic [COUNT_BITS-1:0]     move_count;
	logic [COUNT_BITS-1:0]     click_count;
	logic [COUNT_BITS-1:0]     grab_count;
	logic                      grab_held;
	logic [WINDOW_ID_BITS-1:0] grab_owner;
	logic [STATUS_BITS-1:0]    status;

	modport source (output valid, pos_x, pos_y, buttons_held, new_presses,
		move_count, click_count, grab_count, grab_held, grab_owner, status,
		input ready);
	modport sink (input valid, pos_x, pos_y, buttons_held, new_presses,
		move_count, click_count, grab_count, grab_held, grab_owner, status,
		output ready);
endinterface
`default_nettype wire

>>> rtl/cpt_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cpt_regs import cpt_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                           cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= RESET_WIDTH;
			cfg_q.screen_height <= RESET_HEIGHT;
			cfg_q.speed         <= RESET_SPEED;
			cfg_q.clip_enable   <= 1'b0;
			cfg_q.clip_left     <= '0;
			cfg_q.clip_top      <= '0;
			cfg_q.clip_right    <= '0;
			cfg_q.clip_bottom   <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[COORD_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[COORD_BITS-1:0];
				REG_SPEED:         cfg_q.speed         <= cfg_data[SPEED_BITS-1:0];
				REG_CLIP_ENABLE:   cfg_q.clip_enable   <= cfg_data[0];
				REG_CLIP_LEFT:     cfg_q.clip_left     <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_TOP:      cfg_q.clip_top      <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_RIGHT:    cfg_q.clip_right    <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_BOTTOM:   cfg_q.clip_bottom   <= cfg_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/cpt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_front
// Accepts command items, decodes them and scales move deltas for the queue.
// ----------------------------------------------------------------------------
module cpt_front import cpt_pkg::*; (
	cpt_in_if.sink                 cmd,
	input  wire logic [SPEED_BITS-1:0] speed,
	input  wire logic              full,
	output logic                   push,
	output entry_t                 push_data
);

	function automatic logic signed [DELTA_BITS-1:0] scale_delta(
		input logic [COORD_BITS-1:0] d,
		input logic [SPEED_BITS-1:0] spd
	);
		logic signed [COORD_BITS-1:0] ds;
		logic signed [COORD_BITS:0]   acc;
		logic signed [DELTA_BITS-1:0] a;
		logic signed [DELTA_BITS-1:0] b;
		ds = $signed(d);
		// magnitude above threshold doubles the delta
		if (ds > $signed(COORD_BITS'(ACCEL_THRESHOLD)) ||
			ds < -$signed(COORD_BITS'(ACCEL_THRESHOLD)))
			acc = $signed({d, 1'b0});
		else
			acc = $signed({d[COORD_BITS-1], d});
		a = $signed({{(DELTA_BITS-COORD_BITS-1){acc[COORD_BITS]}}, acc});
		// zero speed behaves as one
		if (spd == '0)
			b = DELTA_BITS'(1);
		else
			b = $signed({{(DELTA_BITS-SPEED_BITS){1'b0}}, spd});
		return a * b;
	endfunction

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	always_comb begin
		push_data.cmd       = cmd_t'(cmd.command);
		push_data.dx        = scale_delta(cmd.delta_x, speed);
		push_data.dy        = scale_delta(cmd.delta_y, speed);
		push_data.abs_x     = cmd.abs_x;
		push_data.abs_y     = cmd.abs_y;
		push_data.buttons   = cmd.button_mask;
		push_data.window_id = cmd.window_id;
	end

endmodule
`default_nettype wire

>>> rtl/cpt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module cpt_queue import cpt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_data,
	output logic        full,
	input  wire logic   pop,
	output entry_t      pop_data,
	output logic        empty
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		if (p == PTR_BITS'(QUEUE_DEPTH - 1))
			return '0;
		return p + PTR_BITS'(1);
	endfunction

	assign full     = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_BITS'(1);
		end
	end

endmodule
`default_nettype wire

>>> rtl/cpt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_back
// Executes queued commands against the cursor state and registers results.
// ----------------------------------------------------------------------------
module cpt_back import cpt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire entry_t head,
	input  wire logic   head_valid,
	output logic        pop,
	cpt_out_if.source   result
);

	logic [COORD_BITS-1:0]     cursor_x_q, cursor_y_q;
	logic [BUTTON_BITS-1:0]    held_q;
	logic [COUNT_BITS-1:0]     moves_q, clicks_q, grabs_q;
	logic                      grab_active_q;
	logic [WINDOW_ID_BITS-1:0] grab_window_q;
	logic                      res_valid_q;
	result_t                   res_q;

	logic [COORD_BITS-1:0]     cursor_x_n, cursor_y_n;
	logic [BUTTON_BITS-1:0]    held_n, fresh;
	logic [COUNT_BITS-1:0]     moves_n, clicks_n, grabs_n;
	logic                      grab_active_n;
	logic [WINDOW_ID_BITS-1:0] grab_window_n;
	grab_status_t              status_n;
	logic signed [SUM_BITS-1:0] sum_x, sum_y;

	function automatic logic signed [SUM_BITS-1:0] widen(input logic [COORD_BITS-1:0] v);
		return $signed({{(SUM_BITS-COORD_BITS){1'b0}}, v});
	endfunction

	// lower bounds first, upper after, so the upper bound wins a conflict
	function automatic logic [COORD_BITS-1:0] clamp_axis(
		input logic signed [SUM_BITS-1:0] p,
		input logic [COORD_BITS-1:0]      size,
		input logic [COORD_BITS-1:0]      clo,
		input logic [COORD_BITS-1:0]      chi,
		input logic                       en
	);
		logic [COORD_BITS-1:0]      lo;
		logic [COORD_BITS-1:0]      hi;
		logic signed [SUM_BITS-1:0] q;
		lo = '0;
		hi = (size != '0) ? size - COORD_BITS'(1) : '0;
		if (en) begin
			lo = clo;
			if (chi != '0 && chi - COORD_BITS'(1) < hi)
				hi = chi - COORD_BITS'(1);
		end
		q = p;
		if (q < widen(lo))
			q = widen(lo);
		if (q > widen(hi))
			q = widen(hi);
		if (q < 0)
			q = '0;
		return q[COORD_BITS-1:0];
	endfunction

	assign pop = head_valid && (!res_valid_q || result.ready);

	always_comb begin
		cursor_x_n    = cursor_x_q;
		cursor_y_n    = cursor_y_q;
		held_n        = held_q;
		fresh         = '0;
		moves_n       = moves_q;
		clicks_n      = clicks_q;
		grabs_n       = grabs_q;
		grab_active_n = grab_active_q;
		grab_window_n = grab_window_q;
		status_n      = ST_OK;
		sum_x = widen(cursor_x_q) + $signed({head.dx[DELTA_BITS-1], head.dx});
		sum_y = widen(cursor_y_q) + $signed({head.dy[DELTA_BITS-1], head.dy});
		case (head.cmd)
			CMD_MOVE: begin
				if (sum_x < 0)
					sum_x = '0;
				if (sum_y < 0)
					sum_y = '0;
				cursor_x_n = clamp_axis(sum_x, cfg.screen_width, cfg.clip_left,
					cfg.clip_right, cfg.clip_enable);
				cursor_y_n = clamp_axis(sum_y, cfg.screen_height, cfg.clip_top,
					cfg.clip_bottom, cfg.clip_enable);
				moves_n = moves_q + COUNT_BITS'(1);
			end
			CMD_SET: begin
				cursor_x_n = clamp_axis(widen(head.abs_x), cfg.screen_width,
					cfg.clip_left, cfg.clip_right, cfg.clip_enable);
				cursor_y_n = clamp_axis(widen(head.abs_y), cfg.screen_height,
					cfg.clip_top, cfg.clip_bottom, cfg.clip_enable);
			end
			CMD_BUTTONS: begin
				fresh  = head.buttons & ~held_q;
				held_n = head.buttons;
				if (fresh != '0)
					clicks_n = clicks_q + COUNT_BITS'(1);
			end
			CMD_RECLAMP: begin
				cursor_x_n = clamp_axis(widen(cursor_x_q), cfg.screen_width,
					cfg.clip_left, cfg.clip_right, cfg.clip_enable);
				cursor_y_n = clamp_axis(widen(cursor_y_q), cfg.screen_height,
					cfg.clip_top, cfg.clip_bottom, cfg.clip_enable);
			end
			CMD_GRAB: begin
				if (grab_active_q && grab_window_q != head.window_id) begin
					status_n = ST_BUSY;
				end else begin
					grab_active_n = 1'b1;
					grab_window_n = head.window_id;
					grabs_n       = grabs_q + COUNT_BITS'(1);
				end
			end
			CMD_RELEASE: begin
				if (grab_active_q) begin
					if (grab_window_q != head.window_id) begin
						status_n = ST_NOT_OWNER;
					end else begin
						grab_active_n = 1'b0;
						grab_window_n = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q    <= RESET_CURSOR_X;
			cursor_y_q    <= RESET_CURSOR_Y;
			held_q        <= '0;
			moves_q       <= '0;
			clicks_q      <= '0;
			grabs_q       <= '0;
			grab_active_q <= 1'b0;
			grab_window_q <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				cursor_x_q    <= cursor_x_n;
				cursor_y_q    <= cursor_y_n;
				held_q        <= held_n;
				moves_q       <= moves_n;
				clicks_q      <= clicks_n;
				grabs_q       <= grabs_n;
				grab_active_q <= grab_active_n;
				grab_window_q <= grab_window_n;
				res_valid_q   <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.pos_x        <= cursor_x_n;
			res_q.pos_y        <= cursor_y_n;
			res_q.buttons_held <= held_n;
			res_q.new_presses  <= fresh;
			res_q.move_count   <= moves_n;
			res_q.click_count  <= clicks_n;
			res_q.grab_count   <= grabs_n;
			res_q.grab_held    <= grab_active_n;
			res_q.grab_owner   <= grab_active_n ? grab_window_n : '0;
			res_q.status       <= status_n;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.pos_x        = res_q.pos_x;
	assign result.pos_y        = res_q.pos_y;
	assign result.buttons_held = res_q.buttons_held;
	assign result.new_presses  = res_q.new_presses;
	assign result.move_count   = res_q.move_count;
	assign result.click_count  = res_q.click_count;
	assign result.grab_count   = res_q.grab_count;
	assign result.grab_held    = res_q.grab_held;
	assign result.grab_owner   = res_q.grab_owner;
	assign result.status       = res_q.status;

endmodule
`default_nettype wire

>>> rtl/cursor_position_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_position_tracker_top
// Cursor tracker: accelerated moves, clamping, buttons and grab ownership.
// ----------------------------------------------------------------------------
// Takes one command per clock while the queue is not full, and returns one
// result per command, in order. An accepted command is decoded and its move
// deltas scaled by the speed register, then it waits in a two-entry queue;
// the back end executes it against the cursor state and registers its result
// in the result register, which holds it until the result side takes it.
// Sustained rate is one command per cycle while the result side is ready, as
// the add-and-clamp on the cursor position in the back end is combinational.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no command is in flight.
module cursor_position_tracker_top import cpt_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	cpt_in_if.sink                         cmd,
	cpt_out_if.source                      result,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t   cfg;
	entry_t push_data;
	entry_t head;
	logic   push;
	logic   full;
	logic   empty;
	logic   pop;

	cpt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpt_front u_front (
		.cmd       (cmd),
		.speed     (cfg.speed),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	cpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	cpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire
